// ===== rtl/core/wpm_pkg.sv =====
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and constants for the wildcard pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

  localparam logic [7:0] SYM_ONE = 8'd63;  // '?'
  localparam logic [7:0] SYM_ANY = 8'd42;  // '*'

  typedef enum logic [1:0] {
    KIND_PATTERN = 2'd0,
    KIND_TEXT    = 2'd1,
    KIND_END     = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic       step;   // text byte accepted: advance live positions
    logic       rearm;  // pattern symbol or end of text: live = position zero
    logic       load;   // pattern symbol goes into the cell at wr_idx
    logic [7:0] sym;    // text byte or pattern symbol
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/wpm_cell.sv =====
// ----------------------------------------------------------------------------
// wpm_cell
// One pattern position: holds its symbol and live bit, passes the star
// closure and the advance bit on to the next position.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_cell import wpm_pkg::*; #(
  parameter int IDX   = 0,
  parameter int LEN_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic [LEN_W-1:0] wr_idx,
  input  wire logic [LEN_W-1:0] length,
  input  wire logic             carry_in,  // closure reaching this position
  input  wire logic             adv_in,    // previous position consumed the byte
  output logic                  carry_out,
  output logic                  adv_out,
  output logic                  closed,
  output logic                  live
);

  logic [7:0] pat_sym;
  logic       live_next;
  logic       in_pat;
  logic       is_star;
  logic       sym_hit;

  assign in_pat  = LEN_W'(IDX) < length;
  assign is_star = pat_sym == SYM_ANY;
  assign sym_hit = (pat_sym == SYM_ONE) || (pat_sym == ctrl.sym);

  // closure ripples through consecutive stars, like a carry chain
  assign closed    = live | carry_in;
  assign carry_out = closed & in_pat & is_star;
  assign adv_out   = closed & in_pat & !is_star & sym_hit;

  always_comb begin
    live_next = live;
    if (ctrl.rearm) begin
      live_next = (IDX == 0);
    end else if (ctrl.step) begin
      live_next = carry_out | adv_in;  // star stays live, plus byte consumed
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= (IDX == 0);
    end else begin
      live <= live_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load && wr_idx == LEN_W'(IDX)) begin
      pat_sym <= ctrl.sym;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wildcard_pattern_match.sv =====
// ----------------------------------------------------------------------------
// wildcard_pattern_match
// Whole-string glob matcher ('?' and '*') built as a chain of position cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries requests of three kinds:
//     KIND_PATTERN appends symbol to the pattern; first=1 starts a new
//       pattern and clears the overflow flag. 63 is '?', 42 is '*'.
//     KIND_TEXT feeds one text byte.
//     KIND_END closes the text and returns one result: matched and
//       pattern_overflow. Kind 3 is accepted and ignored.
//   Pattern symbols and end of text re-arm the matcher for a new text.
//   Output channel (out_valid/out_ready) returns results in request order.
// Timing:
//   One request per cycle while in_ready is high. Each text byte updates all
//   MAX_PATTERN cells in the cycle it is accepted; the star closure ripples
//   along the cell chain. A result appears in the output register in the
//   cycle after its end-of-text request is accepted.
// Stall:
//   While a result sits unclaimed, in_ready is low; it is high whenever the
//   output register is empty or being read in the same cycle.
// Reset:
//   Empty pattern, only position zero live, no overflow, no result pending.
//   Pattern symbol storage is not cleared; only loaded entries are used.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_pattern_match import wpm_pkg::*; #(
  parameter int MAX_PATTERN = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] kind,
  input  wire logic [7:0] symbol,
  input  wire logic       first,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            matched,
  output logic            pattern_overflow
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic             in_fire;
  kind_t            in_kind;
  cell_ctrl_t       ctrl;

  logic [LEN_W-1:0] pattern_len;
  logic [LEN_W-1:0] pattern_len_next;
  logic [LEN_W-1:0] len_base;
  logic             overflowed;
  logic             overflowed_next;
  logic             room;

  logic [MAX_PATTERN:0]   carry;
  logic [MAX_PATTERN:0]   adv;
  logic [MAX_PATTERN:0]   closed_vec;
  logic [MAX_PATTERN:0]   live_vec;
  logic                   live_end;
  logic                   live_end_next;
  logic                   hit;

  assign in_kind  = kind_t'(kind);
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Pattern append: a first symbol restarts at position zero
  assign len_base = first ? '0 : pattern_len;
  assign room     = len_base < LEN_W'(MAX_PATTERN);

  always_comb begin
    ctrl.step  = in_fire && in_kind == KIND_TEXT;
    ctrl.rearm = in_fire && (in_kind == KIND_PATTERN || in_kind == KIND_END);
    ctrl.load  = in_fire && in_kind == KIND_PATTERN && room;
    ctrl.sym   = symbol;
  end

  always_comb begin
    pattern_len_next = pattern_len;
    overflowed_next  = overflowed;
    if (in_fire && in_kind == KIND_PATTERN) begin
      pattern_len_next = room ? len_base + LEN_W'(1) : len_base;
      overflowed_next  = (overflowed && !first) || !room;
    end
  end

  // Cell chain: carry is the star closure, adv the byte-consumed bit
  assign carry[0] = 1'b0;
  assign adv[0]   = 1'b0;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    wpm_cell #(
      .IDX   (i),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .wr_idx    (len_base),
      .length    (pattern_len),
      .carry_in  (carry[i]),
      .adv_in    (adv[i]),
      .carry_out (carry[i+1]),
      .adv_out   (adv[i+1]),
      .closed    (closed_vec[i]),
      .live      (live_vec[i])
    );
  end

  // Terminal position past the last symbol: no symbol of its own
  assign closed_vec[MAX_PATTERN] = live_end | carry[MAX_PATTERN];
  assign live_vec[MAX_PATTERN]   = live_end;

  always_comb begin
    live_end_next = live_end;
    if (ctrl.rearm) begin
      live_end_next = 1'b0;
    end else if (ctrl.step) begin
      live_end_next = adv[MAX_PATTERN];
    end
  end

  // Whole text matched when the closed vector reaches the pattern end and no overflow is flagged
  assign hit = closed_vec[pattern_len] && !overflowed;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len <= '0;
      overflowed  <= 1'b0;
      live_end    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      pattern_len <= pattern_len_next;
      overflowed  <= overflowed_next;
      live_end    <= live_end_next;
      if (in_fire && in_kind == KIND_END) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire && in_kind == KIND_END) begin
      matched          <= hit;
      pattern_overflow <= overflowed;
    end
  end

  // Checks
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    in_fire && (in_kind == KIND_PATTERN || in_kind == KIND_END)
    |=> live_vec == (MAX_PATTERN + 1)'(1))
    else $error("live vector not re-armed");

  a_no_match_on_overflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && matched |-> !pattern_overflow)
    else $error("match reported for overflowed pattern");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    pattern_len <= LEN_W'(MAX_PATTERN))
    else $error("pattern length beyond store");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    overflowed |-> pattern_len == LEN_W'(MAX_PATTERN))
    else $error("overflow flag with store not full");

endmodule

`default_nettype wire

// ===== tb/wildcard_pattern_match_tb.sv =====
// ----------------------------------------------------------------------------
// wildcard_pattern_match_tb
// Self-checking bench for the '?'/'*' whole-string matcher: pattern loads,
// text streams and end-of-text requests are pushed through a random-idling
// valid/ready driver. A bit-vector model of the live positions predicts
// every result, which is checked field by field as it leaves the block.
// ----------------------------------------------------------------------------
module wildcard_pattern_match_tb import wpm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXP = 32;

  // One request on the input channel
  typedef struct {
    kind_t      kind;
    logic [7:0] symbol;
    logic       first;
  } request_t;

  // One result on the output channel
  typedef struct {
    logic matched;
    logic overflow;
  } match_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] kind = KIND_PATTERN;
  logic [7:0] symbol = 8'h00;
  logic       first = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       matched;
  logic       pattern_overflow;

  wildcard_pattern_match #(.MAX_PATTERN(MAXP)) dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .symbol           (symbol),
    .first            (first),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .matched          (matched),
    .pattern_overflow (pattern_overflow)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Glob predictor: its own copy of the pattern store, the live position
  // vector (kept without star closure) and the sticky overflow flag.
  // --------------------------------------------------------------------------
  logic [7:0]    pat_mem [MAXP];
  int            pat_len = 0;
  logic [MAXP:0] live = 1;
  logic          ovf = 1'b0;

  match_result_t awaited_results[$];  // predicted results, oldest first
  request_t      request_queue[$];    // stimulus not yet put on the bus

  // A live '*' at position i also makes position i+1 live (empty run).
  // Walking upward lets a chain of stars propagate in one pass.
  function automatic logic [MAXP:0] close_stars(logic [MAXP:0] v);
    for (int i = 0; i < pat_len; i++)
      if (v[i] && pat_mem[i] == SYM_ANY) v[i+1] = 1'b1;
    return v;
  endfunction

  // Consume one text byte: a star keeps its own position live, a '?' or a
  // literal equal to the byte moves on by one.
  function automatic logic [MAXP:0] advance_live(logic [MAXP:0] v, logic [7:0] c);
    logic [MAXP:0] nv;
    nv = '0;
    v  = close_stars(v);
    for (int i = 0; i < pat_len; i++) begin
      if (v[i]) begin
        if (pat_mem[i] == SYM_ANY) nv[i] = 1'b1;
        else if (pat_mem[i] == SYM_ONE || pat_mem[i] == c) nv[i+1] = 1'b1;
      end
    end
    return nv;
  endfunction

  // Apply one accepted request to the predictor state
  task automatic glob_apply(request_t r);
    logic [MAXP:0] v;
    match_result_t res;
    case (r.kind)
      KIND_PATTERN: begin
        if (r.first) begin
          pat_len = 0;
          ovf     = 1'b0;
        end
        // symbols past the store are dropped and flag overflow
        if (pat_len < MAXP) begin
          pat_mem[pat_len] = r.symbol;
          pat_len++;
        end else begin
          ovf = 1'b1;
        end
        live = 1;
      end
      KIND_TEXT: live = advance_live(live, r.symbol);
      KIND_END: begin
        v = close_stars(live);
        res.matched  = v[pat_len] && !ovf;
        res.overflow = ovf;
        awaited_results.push_back(res);
        live = 1;
      end
      default: ;  // unused kind: no effect at all
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Bookkeeping
  // --------------------------------------------------------------------------
  int err_count     = 0;
  int stim_count    = 0;  // requests queued, ignored kind not counted
  int sent_count    = 0;
  int results_seen  = 0;
  int matched_seen  = 0;
  int overflow_seen = 0;

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Idle density per stretch: none, light, medium, heavy
  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 50;
    endcase
  endfunction

  int idle_pct   = 20;
  int stall_pct  = 20;
  int gap_left   = 0;
  int stall_left = 0;
  bit calm       = 1'b0;  // tail of the run: no idling on either side

  // --------------------------------------------------------------------------
  // Driver: pops requests, holds each until accepted, feeds the predictor at
  // the accepting edge, and inserts random gaps between requests.
  // --------------------------------------------------------------------------
  request_t cur_req;

  always @(posedge clk) begin : drive_requests
    logic take;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      take = !in_valid || in_ready;
      if (in_valid && in_ready) begin
        glob_apply(cur_req);
        sent_count++;
        if (sent_count % 100 == 0) idle_pct = pick_pct();
      end
      if (take) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          cur_req = request_queue.pop_front();
          in_valid <= 1'b1;
          kind     <= cur_req.kind;
          symbol   <= cur_req.symbol;
          first    <= cur_req.first;
          // a burst started here opens after this request is taken
          if (!calm && $urandom_range(0, 99) < idle_pct)
            gap_left = $urandom_range(1, 14);
        end
      end
      calm <= (request_queue.size() < 120);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each taken result against the oldest prediction and
  // drops out_ready in random bursts.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    match_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (matched) matched_seen++;
        if (pattern_overflow) overflow_seen++;
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no request awaiting one");
        end else begin
          want = awaited_results.pop_front();
          if (matched !== want.matched)
            report_mismatch($sformatf("result %0d matched=%b, want %b",
                                      results_seen, matched, want.matched));
          if (pattern_overflow !== want.overflow)
            report_mismatch($sformatf("result %0d pattern_overflow=%b, want %b",
                                      results_seen, pattern_overflow, want.overflow));
        end
        if (results_seen % 40 == 0) stall_pct = pick_pct();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < stall_pct)
          stall_left = $urandom_range(1, 14);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------
  logic [7:0] stim_pattern[$];  // generator's view of the current pattern

  task automatic add_req(kind_t k, logic [7:0] s, logic f);
    request_t r;
    r.kind   = k;
    r.symbol = s;
    r.first  = f;
    request_queue.push_back(r);
    if (k != KIND_NONE) stim_count++;
  endtask

  // Mostly a tiny alphabet so literals line up; sometimes any byte
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 7) < 6) return 8'h61 + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_pattern_symbol();
    case ($urandom_range(0, 9))
      0, 1:    return SYM_ONE;
      2, 3:    return SYM_ANY;
      default: return pick_byte();
    endcase
  endfunction

  task automatic load_pattern(int n);
    logic [7:0] s;
    stim_pattern.delete();
    for (int i = 0; i < n; i++) begin
      s = pick_pattern_symbol();
      stim_pattern.push_back(s);
      add_req(KIND_PATTERN, s, i == 0);
    end
  endtask

  // Build a text that fits the pattern, then sometimes break it by one edit
  task automatic send_text();
    logic [7:0] txt[$];
    int         spot;
    foreach (stim_pattern[i]) begin
      if (stim_pattern[i] == SYM_ANY)
        repeat ($urandom_range(0, 3)) txt.push_back(pick_byte());
      else if (stim_pattern[i] == SYM_ONE)
        txt.push_back(8'($urandom_range(0, 255)));
      else
        txt.push_back(stim_pattern[i]);
    end
    spot = (txt.size() > 0) ? $urandom_range(0, txt.size() - 1) : 0;
    case ($urandom_range(0, 5))
      0: if (txt.size() > 0) txt[spot] = pick_byte();
      1: if (txt.size() > 0) txt.delete(spot);
      2: txt.insert($urandom_range(0, txt.size()), pick_byte());
      default: ;
    endcase
    foreach (txt[i]) add_req(KIND_TEXT, txt[i], 1'($urandom_range(0, 1)));
    add_req(KIND_END, pick_byte(), 1'($urandom_range(0, 1)));
  endtask

  task automatic build_stimulus();
    // Directed: empty pattern straight out of reset matches only empty text
    add_req(KIND_END, 8'h00, 1'b0);
    add_req(KIND_TEXT, 8'h00, 1'b0);
    add_req(KIND_END, 8'hFF, 1'b1);
    // unused kind must leave everything alone
    add_req(KIND_NONE, 8'hFF, 1'b1);
    // lone star against empty text
    add_req(KIND_PATTERN, SYM_ANY, 1'b1);
    add_req(KIND_END, 8'h00, 1'b0);
    // "*\xff" against "\x00\xff": extreme byte values
    add_req(KIND_PATTERN, 8'hFF, 1'b0);
    add_req(KIND_TEXT, 8'h00, 1'b1);
    add_req(KIND_TEXT, 8'hFF, 1'b0);
    add_req(KIND_END, 8'h00, 1'b0);
    // pattern symbol arriving mid-text re-arms the live vector
    add_req(KIND_PATTERN, SYM_ONE, 1'b1);
    add_req(KIND_TEXT, 8'h00, 1'b0);
    add_req(KIND_PATTERN, 8'h00, 1'b0);
    add_req(KIND_TEXT, 8'hAA, 1'b0);
    add_req(KIND_TEXT, 8'h00, 1'b0);
    add_req(KIND_END, 8'h00, 1'b0);
    // text bytes with no end, then a new pattern, then an empty text
    add_req(KIND_TEXT, 8'h61, 1'b0);
    add_req(KIND_TEXT, 8'h61, 1'b0);
    add_req(KIND_PATTERN, 8'h61, 1'b1);
    add_req(KIND_END, 8'h00, 1'b0);
    // double star then literal
    add_req(KIND_PATTERN, SYM_ANY, 1'b1);
    add_req(KIND_PATTERN, SYM_ANY, 1'b0);
    add_req(KIND_PATTERN, 8'h62, 1'b0);
    add_req(KIND_TEXT, 8'h62, 1'b0);
    add_req(KIND_END, 8'h00, 1'b0);

    // Random: mostly fresh patterns with fitting texts, plus noise
    while (stim_count < 1550) begin
      case ($urandom_range(0, 19))
        14: add_req(KIND_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        15: add_req(kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        16: repeat ($urandom_range(1, 3)) begin
              // extend the pattern without restarting it
              stim_pattern.push_back(pick_pattern_symbol());
              add_req(KIND_PATTERN, stim_pattern[$], 1'b0);
            end
        17: repeat ($urandom_range(1, 3))
              add_req(KIND_TEXT, pick_byte(), 1'($urandom_range(0, 1)));
        18: add_req(KIND_END, pick_byte(), 1'($urandom_range(0, 1)));
        19: begin
          // around and past the store size: overflow and the exact fit
          load_pattern($urandom_range(MAXP - 2, MAXP + 4));
          repeat ($urandom_range(1, 3)) send_text();
        end
        default: begin
          load_pattern($urandom_range(1, 8));
          repeat ($urandom_range(1, 4)) send_text();
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Run control
  // --------------------------------------------------------------------------
  initial begin
    int total_reqs;
    build_stimulus();
    total_reqs = request_queue.size();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // every request accepted, then every result back, then a short settle
    while (sent_count < total_reqs) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d requests (%0d counted as stimulus), checked %0d results",
             sent_count, stim_count, results_seen);
    $display("  %0d texts matched, %0d results flagged pattern overflow",
             matched_seen, overflow_seen);
    if (err_count == 0) begin
      $display("wildcard_pattern_match_tb OK");
    end else begin
      $display("wildcard_pattern_match_tb NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(2_000_000);
    $display("Watchdog expired with %0d results outstanding",
             awaited_results.size());
    $display("wildcard_pattern_match_tb NOT OK");
    $finish;
  end

endmodule
